// File: rtl/smallest_factor_sieve_factorizer_top_assert.svh
// Assertion macros for the smallest-factor sieve factorizer.
// Included by the top level; define ASSERT_OFF to compile them out.
`ifndef SMALLEST_FACTOR_SIEVE_FACTORIZER_TOP_ASSERT_SVH
`define SMALLEST_FACTOR_SIEVE_FACTORIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, held off during reset
`define SFSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, held off during reset
`define SFSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SFSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SFSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/sfsf_pkg.sv
// Shared types, constants and helpers for the smallest-factor sieve factorizer.
// No dependencies; used by sfsf_div and the top level.
`timescale 1ns / 1ps

package sfsf_pkg;

	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned EXP_W       = 5;
	localparam int unsigned MAX_VALUE   = 65535;
	localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'hFFFF;
	localparam int unsigned DIV_CNT_W   = $clog2(VALUE_W);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_INIT = 10'b00_0000_0010,
		S_PRD  = 10'b00_0000_0100,
		S_PCK  = 10'b00_0000_1000,
		S_MRD  = 10'b00_0001_0000,
		S_MWR  = 10'b00_0010_0000,
		S_FRD  = 10'b00_0100_0000,
		S_FCK  = 10'b00_1000_0000,
		S_DIV  = 10'b01_0000_0000,
		S_DCK  = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic               status;
		logic [VALUE_W-1:0] prime;
		logic [EXP_W-1:0]   exponent;
		logic               last;
	} res_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [VALUE_W-1:0] divisor;
	} div_req_t;

	function automatic res_t mk_res(input logic st, input logic [VALUE_W-1:0] pr,
			input logic [EXP_W-1:0] ex, input logic lst);
		res_t r;
		r.status   = st;
		r.prime    = pr;
		r.exponent = ex;
		r.last     = lst;
		return r;
	endfunction

endpackage

// File: rtl/sfsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the smallest-divisor table.
`timescale 1ns / 1ps

module sfsf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sfsf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sfsf_pkg for the request struct and widths.
`timescale 1ns / 1ps

module sfsf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfsf_pkg::div_req_t            req,
	output logic                          done,
	output logic [sfsf_pkg::VALUE_W-1:0]  quotient
);

	localparam int unsigned W  = sfsf_pkg::VALUE_W;
	localparam int unsigned CW = sfsf_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [W:0]    shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[W-1]};
	assign fits    = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= W'(shifted - {1'b0, dsr_q});
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/smallest_factor_sieve_factorizer_top.sv
// Build: writes every table entry up to the limit, then reads and checks each odd candidate
// and, for each prime found, reads each multiple from its square on and marks it if unmarked.
// Factorize: one table read for the value, then one division by the shared divider per prime
// factor with multiplicity, each followed by a table read of the quotient; errors and value one answer
// the cycle after the request. One request at a time; busy is high while a build or factorization runs; results are
// one-cycle strobes the receiver cannot stall. arst_n clears control and ready, not the RAM.
`timescale 1ns / 1ps

module smallest_factor_sieve_factorizer_top #(
	parameter int unsigned MAX_VALUE = sfsf_pkg::MAX_VALUE
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sieve_limit_we,
	input  logic [sfsf_pkg::VALUE_W-1:0]  sieve_limit,
	input  logic                          start,
	input  logic                          mode,
	input  logic [sfsf_pkg::VALUE_W-1:0]  value,
	output logic                          busy,
	output logic                          strobe,
	output logic                          status,
	output logic [sfsf_pkg::VALUE_W-1:0]  prime,
	output logic [sfsf_pkg::EXP_W-1:0]    exponent,
	output logic                          last
);

	`include "smallest_factor_sieve_factorizer_top_assert.svh"

	localparam int unsigned DEPTH = MAX_VALUE + 1;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned VW    = sfsf_pkg::VALUE_W;
	localparam int unsigned EW    = sfsf_pkg::EXP_W;

	sfsf_pkg::state_t state_q;
	sfsf_pkg::res_t   res_q;
	logic             strobe_q;
	logic [VW-1:0]    limit_q;
	logic [AW-1:0]    built_q;
	logic             ready_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    p_q;
	logic [AW:0]      sq_q;
	logic [AW:0]      j_q;
	logic [VW-1:0]    n_q;
	logic [VW-1:0]    fp_q;
	logic [EW-1:0]    exp_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    wdata;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    rdata;

	sfsf_pkg::div_req_t div_req;
	logic               div_done;
	logic [VW-1:0]      div_quo;

	logic [AW-1:0] lim_c;
	logic [AW-1:0] p_nx;
	logic [AW:0]   sq_nx;
	logic [AW:0]   j_nx;
	logic [VW-1:0] rd_p16;
	logic          bad_req;

	sfsf_ram #(
		.WIDTH(AW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	sfsf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign lim_c   = (32'(limit_q) > MAX_VALUE) ? AW'(MAX_VALUE) : AW'(limit_q);
	// (p+2)^2 = p^2 + 4p + 4
	assign p_nx    = p_q + AW'(2);
	assign sq_nx   = sq_q + ({1'b0, p_q} << 2) + (AW + 1)'(4);
	assign j_nx    = j_q + {1'b0, p_q};
	assign rd_p16  = VW'(rdata);
	assign bad_req = !ready_q || (value == '0) || (32'(value) > 32'(built_q));

	always_comb begin
		case (state_q)
			sfsf_pkg::S_PRD: raddr = p_q;
			sfsf_pkg::S_MRD: raddr = j_q[AW-1:0];
			sfsf_pkg::S_FRD: raddr = AW'(n_q);
			sfsf_pkg::S_DIV: raddr = AW'(div_quo);
			default:         raddr = '0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = j_q[AW-1:0];
		wdata = p_q;
		if (state_q == sfsf_pkg::S_INIT) begin
			we    = 1'b1;
			waddr = idx_q;
			// evens from 4 get 2, everything else holds itself
			wdata = (idx_q >= AW'(4) && !idx_q[0]) ? AW'(2) : idx_q;
		end else if (state_q == sfsf_pkg::S_MWR) begin
			we = (rdata == j_q[AW-1:0]);
		end
	end

	always_comb begin
		div_req.dividend = n_q;
		div_req.divisor  = rd_p16;
		div_req.start    = ((state_q == sfsf_pkg::S_FCK) && (rdata >= AW'(2))) ||
			((state_q == sfsf_pkg::S_DCK) && (n_q != VW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sfsf_pkg::LIMIT_RESET;
		end else if (sieve_limit_we) begin
			limit_q <= sieve_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sfsf_pkg::S_IDLE;
			ready_q  <= 1'b0;
			built_q  <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
			idx_q    <= '0;
			p_q      <= '0;
			sq_q     <= '0;
			j_q      <= '0;
			n_q      <= '0;
			fp_q     <= '0;
			exp_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				sfsf_pkg::S_IDLE: begin
					if (start) begin
						if (!mode) begin
							built_q <= lim_c;
							idx_q   <= '0;
							state_q <= sfsf_pkg::S_INIT;
						end else if (bad_req) begin
							strobe_q <= 1'b1;
							res_q    <= sfsf_pkg::mk_res(1'b1, '0, '0, 1'b1);
						end else if (value == VW'(1)) begin
							strobe_q <= 1'b1;
							res_q    <= sfsf_pkg::mk_res(1'b0, '0, '0, 1'b1);
						end else begin
							n_q     <= value;
							state_q <= sfsf_pkg::S_FRD;
						end
					end
				end
				sfsf_pkg::S_INIT: begin
					if (idx_q == built_q) begin
						p_q  <= AW'(3);
						sq_q <= (AW + 1)'(9);
						if ((AW + 1)'(9) > {1'b0, built_q}) begin
							ready_q  <= 1'b1;
							strobe_q <= 1'b1;
							res_q    <= sfsf_pkg::mk_res(1'b0, '0, '0, 1'b1);
							state_q  <= sfsf_pkg::S_IDLE;
						end else begin
							state_q <= sfsf_pkg::S_PRD;
						end
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				sfsf_pkg::S_PRD: begin
					state_q <= sfsf_pkg::S_PCK;
				end
				sfsf_pkg::S_PCK: begin
					if (rdata == p_q) begin
						j_q     <= sq_q;
						state_q <= sfsf_pkg::S_MRD;
					end else begin
						p_q  <= p_nx;
						sq_q <= sq_nx;
						if (sq_nx > {1'b0, built_q}) begin
							ready_q  <= 1'b1;
							strobe_q <= 1'b1;
							res_q    <= sfsf_pkg::mk_res(1'b0, '0, '0, 1'b1);
							state_q  <= sfsf_pkg::S_IDLE;
						end else begin
							state_q <= sfsf_pkg::S_PRD;
						end
					end
				end
				sfsf_pkg::S_MRD: begin
					state_q <= sfsf_pkg::S_MWR;
				end
				sfsf_pkg::S_MWR: begin
					j_q <= j_nx;
					if (j_nx > {1'b0, built_q}) begin
						p_q  <= p_nx;
						sq_q <= sq_nx;
						if (sq_nx > {1'b0, built_q}) begin
							ready_q  <= 1'b1;
							strobe_q <= 1'b1;
							res_q    <= sfsf_pkg::mk_res(1'b0, '0, '0, 1'b1);
							state_q  <= sfsf_pkg::S_IDLE;
						end else begin
							state_q <= sfsf_pkg::S_PRD;
						end
					end else begin
						state_q <= sfsf_pkg::S_MRD;
					end
				end
				sfsf_pkg::S_FRD: begin
					state_q <= sfsf_pkg::S_FCK;
				end
				sfsf_pkg::S_FCK: begin
					if (rdata < AW'(2)) begin
						strobe_q <= 1'b1;
						res_q    <= sfsf_pkg::mk_res(1'b0, '0, '0, 1'b1);
						state_q  <= sfsf_pkg::S_IDLE;
					end else begin
						fp_q    <= rd_p16;
						exp_q   <= '0;
						state_q <= sfsf_pkg::S_DIV;
					end
				end
				sfsf_pkg::S_DIV: begin
					if (div_done) begin
						n_q     <= div_quo;
						exp_q   <= exp_q + EW'(1);
						state_q <= sfsf_pkg::S_DCK;
					end
				end
				sfsf_pkg::S_DCK: begin
					// rdata is the smallest divisor of the new quotient
					if (n_q == VW'(1)) begin
						strobe_q <= 1'b1;
						res_q    <= sfsf_pkg::mk_res(1'b0, fp_q, exp_q, 1'b1);
						state_q  <= sfsf_pkg::S_IDLE;
					end else if (rd_p16 == fp_q) begin
						state_q <= sfsf_pkg::S_DIV;
					end else begin
						strobe_q <= 1'b1;
						res_q    <= sfsf_pkg::mk_res(1'b0, fp_q, exp_q, 1'b0);
						fp_q     <= rd_p16;
						exp_q    <= '0;
						state_q  <= sfsf_pkg::S_DIV;
					end
				end
				default: begin
					state_q <= sfsf_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != sfsf_pkg::S_IDLE);
	assign strobe   = strobe_q;
	assign status   = res_q.status;
	assign prime    = res_q.prime;
	assign exponent = res_q.exponent;
	assign last     = res_q.last;

	`SFSF_ASSERT_IMP(a_more_follow, clk, arst_n, strobe && !last, busy, "non-last result while idle")
	`SFSF_ASSERT_IMP(a_err_shape, clk, arst_n, strobe && status, last && (prime == '0) && (exponent == '0), "malformed error result")
	`SFSF_ASSERT_NXT(a_build_busy, clk, arst_n, start && !busy && !mode, busy, "build request did not start")
	`SFSF_ASSERT_IMP(a_div_ready, clk, arst_n, state_q == sfsf_pkg::S_DIV, ready_q, "factorizing without a built table")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for smallest_factor_sieve_factorizer_top: directed and random build and factorize
// requests, checked in order against a divisor table that the bench sieves for itself.
// Depends on sfsf_pkg and the top-level RTL only.

module tb_top;
	import sfsf_pkg::*;

	localparam logic MODE_BUILD  = 1'b0;
	localparam logic MODE_FACTOR = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_ERR  = 1'b1;
	localparam int   MAX_PRIMES  = 6;
	localparam int   TAIL_CYCLES = 400;
	localparam int   SEG_ITEMS   = 24;
	localparam int   SMALL_PRIMES [6] = '{2, 3, 5, 7, 11, 13};

	// Holds the bench's own divisor table and the factor results still owed by the block.
	class factor_book;
		bit [VALUE_W-1:0] spf [MAX_VALUE+1];
		bit               ready;
		int               built_lim;
		int               limit_reg;
		res_t             due[$];
		int               errors;

		function new();
			ready     = 1'b0;
			built_lim = 0;
			limit_reg = int'(LIMIT_RESET);
			errors    = 0;
		endfunction

		function void queue_res(logic st, logic [VALUE_W-1:0] pr, logic [EXP_W-1:0] ex,
				logic lst);
			res_t r;
			r.status   = st;
			r.prime    = pr;
			r.exponent = ex;
			r.last     = lst;
			due.push_back(r);
		endfunction

		function void sieve_table();
			int lim;
			lim = (limit_reg > int'(MAX_VALUE)) ? int'(MAX_VALUE) : limit_reg;
			for (int i = 0; i <= lim; i++)
				spf[i] = VALUE_W'(i);
			for (int i = 4; i <= lim; i += 2)
				spf[i] = 2;
			for (int i = 3; i * i <= lim; i += 2) begin
				if (spf[i] != VALUE_W'(i))
					continue;
				for (int j = i * i; j <= lim; j += i)
					if (spf[j] == VALUE_W'(j))
						spf[j] = VALUE_W'(i);
			end
			built_lim = lim;
			ready     = 1'b1;
		endfunction

		// Works out the results owed for one accepted request.
		function void take_request(logic m, logic [VALUE_W-1:0] v);
			int n, p, cnt, k;
			if (m == MODE_BUILD) begin
				sieve_table();
				queue_res(STATUS_OK, '0, '0, 1'b1);
				return;
			end
			if (!ready || v == 0 || int'(v) > built_lim) begin
				queue_res(STATUS_ERR, '0, '0, 1'b1);
				return;
			end
			if (v == 1) begin
				queue_res(STATUS_OK, '0, '0, 1'b1);
				return;
			end
			n = int'(v);
			k = 0;
			while (k < MAX_PRIMES) begin
				p = int'(spf[n]);
				if (p < 2)
					break;
				cnt = 0;
				do begin
					n = n / p;
					cnt++;
				end while (n % p == 0);
				// spf[1] is 1, so the walk ends once the value is used up
				queue_res(STATUS_OK, VALUE_W'(p), EXP_W'(cnt), (n == 1) || (k + 1 == MAX_PRIMES));
				k++;
			end
		endfunction

		function void flag(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_factor(logic st, logic [VALUE_W-1:0] pr, logic [EXP_W-1:0] ex,
				logic lst);
			res_t want;
			if (due.size() == 0) begin
				$display("%0t unexpected result: status %0d prime %0d exponent %0d last %0d",
					$time, st, pr, ex, lst);
				errors++;
				return;
			end
			want = due.pop_front();
			if (st !== want.status)
				flag("status", VALUE_W'(want.status), VALUE_W'(st));
			if (pr !== want.prime)
				flag("prime", want.prime, pr);
			if (ex !== want.exponent)
				flag("exponent", VALUE_W'(want.exponent), VALUE_W'(ex));
			if (lst !== want.last)
				flag("last", VALUE_W'(want.last), VALUE_W'(lst));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               sieve_limit_we;
	logic [VALUE_W-1:0] sieve_limit;
	logic               start;
	logic               mode;
	logic [VALUE_W-1:0] value;
	logic               busy;
	logic               strobe;
	logic               status;
	logic [VALUE_W-1:0] prime;
	logic [EXP_W-1:0]   exponent;
	logic               last;

	factor_book book = new();
	int         send_idle_pct;

	smallest_factor_sieve_factorizer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sieve_limit_we (sieve_limit_we),
		.sieve_limit    (sieve_limit),
		.start          (start),
		.mode           (mode),
		.value          (value),
		.busy           (busy),
		.strobe         (strobe),
		.status         (status),
		.prime          (prime),
		.exponent       (exponent),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(50_000_000);
		$display("Verification failed");
		$finish;
	end

	// results cannot be held off: take every strobe
	always @(posedge clk) begin
		if (arst_n && strobe)
			book.check_factor(status, prime, exponent, last);
	end

	// Holds start high until the request is taken; start stays high on return.
	task automatic issue(input logic m, input logic [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode  <= m;
		value <= v;
		do @(posedge clk); while (busy);
		book.take_request(m, v);
	endtask

	// Stop sending and wait for all owed results and for the block to go idle.
	task automatic settle();
		start <= 1'b0;
		while (book.due.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [VALUE_W-1:0] lim);
		sieve_limit_we <= 1'b1;
		sieve_limit    <= lim;
		@(posedge clk);
		sieve_limit_we <= 1'b0;
		book.limit_reg = int'(lim);
	endtask

	initial begin
		int v, p, lim, bl, r, builds;
		arst_n         = 1'b0;
		sieve_limit_we = 1'b0;
		sieve_limit    = '0;
		start          = 1'b0;
		mode           = MODE_BUILD;
		value          = '0;
		send_idle_pct  = 25;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// queries before any build
		issue(MODE_FACTOR, 16'd12);
		issue(MODE_FACTOR, 16'd0);
		settle();

		// full-range table
		write_limit(16'hFFFF);
		issue(MODE_BUILD, 16'hFFFF);
		issue(MODE_FACTOR, 16'd1);
		issue(MODE_FACTOR, 16'd65535);
		issue(MODE_FACTOR, 16'd65521);
		issue(MODE_FACTOR, 16'd30030);  // six distinct primes
		issue(MODE_FACTOR, 16'd32768);
		issue(MODE_FACTOR, 16'd2);
		issue(MODE_FACTOR, 16'd4);
		issue(MODE_FACTOR, 16'd0);
		issue(MODE_FACTOR, 16'd62208);
		issue(MODE_FACTOR, 16'd59049);
		settle();

		// new limit only takes effect at the next build
		write_limit(16'd100);
		issue(MODE_FACTOR, 16'd65535);
		issue(MODE_BUILD, 16'h0000);
		issue(MODE_FACTOR, 16'd101);
		issue(MODE_FACTOR, 16'd100);
		issue(MODE_FACTOR, 16'd97);
		settle();

		// degenerate tables
		write_limit(16'd1);
		issue(MODE_BUILD, 16'h5A5A);
		issue(MODE_FACTOR, 16'd1);
		issue(MODE_FACTOR, 16'd2);
		settle();
		write_limit(16'd0);
		issue(MODE_BUILD, 16'hA5A5);
		issue(MODE_FACTOR, 16'd1);
		issue(MODE_FACTOR, 16'h8000);
		settle();
		write_limit(16'd2);
		issue(MODE_BUILD, 16'h0001);
		issue(MODE_FACTOR, 16'd2);
		issue(MODE_FACTOR, 16'd3);

		for (int seg = 0; seg < 6; seg++) begin
			settle();
			send_idle_pct = (seg < 2) ? 25 : (seg < 4) ? 83 : 0;
			case (seg)
				1: lim = $urandom_range(4096, 12000);
				3: lim = $urandom_range(0, 40);
				default: lim = $urandom_range(2, 1500);
			endcase
			write_limit(VALUE_W'(lim));
			builds = 0;
			for (int i = 0; i < SEG_ITEMS; i++) begin
				// builds are slow: cap them per segment
				if (i == 0 || (builds < 3 && $urandom_range(0, 11) == 0)) begin
					issue(MODE_BUILD, VALUE_W'($urandom));
					builds++;
				end else begin
					r  = $urandom_range(0, 99);
					bl = book.built_lim;
					if (r < 45 && bl >= 1) begin
						v = $urandom_range(1, bl);
					end else if (r < 80) begin
						// smooth numbers give long factor lists
						v = 1;
						repeat ($urandom_range(1, 14)) begin
							p = SMALL_PRIMES[$urandom_range(0, 5)];
							if (v * p <= bl)
								v = v * p;
						end
					end else if (r < 87) begin
						v = 0;
					end else if (r < 94) begin
						v = (bl < 65535) ? $urandom_range(bl + 1, 65535) : 65535;
					end else begin
						v = $urandom_range(0, 65535);
					end
					issue(MODE_FACTOR, VALUE_W'(v));
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
